// ===== src/was_pkg.sv =====
// ----------------------------------------------------------------------------
// was_pkg - wake-up alarm scheduler shared definitions
// Command and register codes, sequencer states and the constants that feed
// the shared multiply-add unit.
// ----------------------------------------------------------------------------
package was_pkg;

	// command codes (carried in s_tuser)
	localparam logic [2:0] CMD_ADVANCE = 3'd0;
	localparam logic [2:0] CMD_ADJUST  = 3'd1;
	localparam logic [2:0] CMD_SET     = 3'd2;
	localparam logic [2:0] CMD_ALIGN   = 3'd3;
	localparam logic [2:0] CMD_QUERY   = 3'd4;
	localparam logic [2:0] CMD_STOP    = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_PERIOD_HOURS   = 3'd0;
	localparam logic [2:0] CFG_PERIOD_MINUTES = 3'd1;
	localparam logic [2:0] CFG_PERIOD_SECONDS = 3'd2;
	localparam logic [2:0] CFG_SLOT_MINUTES   = 3'd3;
	localparam logic [2:0] CFG_SLOT_OFFSET    = 3'd4;

	localparam logic [5:0] SLOT_RESET = 6'd15;
	localparam logic [5:0] SLOT_LONG  = 6'd30;

	// shared unit widths
	localparam int OP_A_W = 20;
	localparam int OP_B_W = 28;
	localparam int ACC_W  = 32;

	// multiplier constants
	localparam logic signed [OP_B_W-1:0] K_ONE       = 28'sd1;
	localparam logic signed [OP_B_W-1:0] K_NEG_ONE   = -28'sd1;
	localparam logic signed [OP_B_W-1:0] K_MIN       = 28'sd60;
	localparam logic signed [OP_B_W-1:0] K_NEG_MIN   = -28'sd60;
	localparam logic signed [OP_B_W-1:0] K_HOUR      = 28'sd3600;
	localparam logic signed [OP_B_W-1:0] K_NEG_HOUR  = -28'sd3600;
	localparam logic signed [OP_B_W-1:0] K_HOUR_RCP  = 28'sd1165;
	localparam logic signed [OP_B_W-1:0] K_MIN_RCP   = 28'sd1092;
	localparam logic signed [OP_B_W-1:0] K_HUNDRED   = 28'sd100;
	localparam logic signed [OP_B_W-1:0] K_TEN_K     = 28'sd10000;
	localparam logic signed [OP_B_W-1:0] K_MILLION   = 28'sd1000000;
	localparam logic signed [OP_B_W-1:0] K_HUND_MIL  = 28'sd100000000;

	// reciprocal shifts: t*1165 >> 22 ~ t/3600, r*1092 >> 16 ~ r/60
	localparam int HOUR_SHIFT = 22;
	localparam int MIN_SHIFT  = 16;

	localparam logic signed [ACC_W-1:0] SEC_PER_MIN  = 32'sd60;
	localparam logic signed [ACC_W-1:0] SEC_PER_HOUR = 32'sd3600;
	localparam logic signed [ACC_W-1:0] SEC_PER_DAY  = 32'sd86400;
	localparam logic signed [ACC_W-1:0] SEC_TWO_DAYS = 32'sd172800;

	localparam logic [6:0] YEAR_WRAP = 7'd100;

	localparam int DIV_STEPS = 6;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_DIV,
		ST_PREP,
		ST_TOT_MS,
		ST_TOT_H,
		ST_WRAP,
		ST_HOUR_Q,
		ST_HOUR_R,
		ST_MIN_Q,
		ST_MIN_R,
		ST_DIFF_S,
		ST_DIFF_M,
		ST_DIFF_H,
		ST_STAMP_HM,
		ST_STAMP_YR,
		ST_STAMP_DAY,
		ST_STAMP_MON,
		ST_STAMP_MS,
		ST_FINISH
	} state_t;

endpackage

// ===== src/wakeup_alarm_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// wakeup_alarm_scheduler_unit - wake-up alarm time-of-day scheduler
// Keeps one alarm time and applies advance, adjust, set, align, query and
// stop commands; reports the alarm, seconds until it and clock stamps.
// ----------------------------------------------------------------------------
// One item is taken at a time. Each command is worked through a single
// signed multiply-add unit (acc = a*b + c) stepped by a small sequencer:
// operands are formed, the new alarm total is built and wrapped into one
// day, split back into hour, minute and second by reciprocal multiplies
// with one correction each, then seconds-until-alarm and both stamps are
// built in the same unit. Align commands first go through an offset/borrow
// step and a restoring divider that finds minute mod slot length. The
// result sits in an output register, so the next item can be accepted while
// it waits; the result load stalls only if the previous one is still held.
// Configuration writes are always taken and are meant for idle periods.
// Register indexes: 0 period hours, 1 period minutes, 2 period seconds,
// 3 slot minutes (reset 15, zero acts as one), 4 signed slot second offset.
module wakeup_alarm_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_month, now_day, now_year, now_hour, now_minute, now_second,
	// adjust_seconds, new_alarm_hour, new_alarm_minute, new_alarm_second, pad
	input  logic [63:0] s_tdata,
	// command
	input  logic [2:0]  s_tuser,
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// alarm_hour, alarm_minute, alarm_second, seconds_until_alarm,
	// date_stamp, minute_second_stamp, pad
	output logic [79:0] m_tdata,
	// arm_request, disarm_request
	output logic [1:0]  m_tuser,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int AW = was_pkg::ACC_W;

	was_pkg::state_t state_q, state_d;

	// configuration
	logic [4:0]        period_h_q;
	logic [5:0]        period_m_q;
	logic [5:0]        period_s_q;
	logic [5:0]        slot_q;
	logic signed [6:0] offset_q;

	// stored alarm
	logic [4:0] alarm_h_q;
	logic [5:0] alarm_m_q;
	logic [5:0] alarm_s_q;

	// captured item
	logic [2:0]         cmd_q;
	logic [3:0]         mon_q;
	logic [4:0]         day_q;
	logic [6:0]         year_q;
	logic [4:0]         nh_q;
	logic [5:0]         nm_q;
	logic [5:0]         ns_q;
	logic signed [12:0] adj_q;
	logic [4:0]         new_h_q;
	logic [5:0]         new_m_q;
	logic [5:0]         new_s_q;

	// align working values
	logic [5:0]        al_h_q, al_h_c;
	logic [5:0]        al_m_q, al_m_c;
	logic signed [6:0] al_off_q, al_off_c;
	logic              al_b_q;
	logic [5:0]        div_rem_q;
	logic [5:0]        div_dvd_q;
	logic [2:0]        div_cnt_q;

	// new alarm operands
	logic signed [7:0]  h_q, h_c;
	logic signed [7:0]  m_q, m_c;
	logic signed [13:0] s_q, s_c;

	// split / results
	logic [16:0] t_q;
	logic [4:0]  hour_q;
	logic [11:0] r_q;
	logic [5:0]  min_q;
	logic [17:0] diff_q;
	logic [30:0] date_q;

	// shared multiply-add unit
	logic signed [was_pkg::OP_A_W-1:0]             op_a;
	logic signed [was_pkg::OP_B_W-1:0]             op_b;
	logic signed [AW-1:0]                          op_c;
	logic signed [was_pkg::OP_A_W+was_pkg::OP_B_W-1:0] prod;
	logic signed [AW-1:0]                          unit_res;
	logic signed [AW-1:0]                          acc_q;

	// output register
	logic        out_valid_q;
	logic [79:0] out_data_q;
	logic [1:0]  out_user_q;

	logic s_accept;
	logic out_load;

	assign prod     = op_a * op_b;
	assign unit_res = $signed(prod[AW-1:0]) + op_c;

	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;

	// ---- small helpers on the datapath ----
	logic [5:0]        slot_eff;
	logic              slot_long;
	logic              off_neg;
	logic signed [7:0] late_lim;
	logic              late;
	logic [6:0]        rem_shift;
	logic [6:0]        rem_next;
	logic              hr_fix;
	logic [11:0]       r_c;
	logic              sec_fix;
	logic [5:0]        sec_c;
	logic [6:0]        year_mod;
	logic signed [AW-1:0] wrap_k;
	logic signed [7:0] slot_lim;
	logic signed [7:0] slot_min;

	assign slot_eff  = (slot_q == 6'd0) ? 6'd1 : slot_q;
	assign slot_long = slot_eff > was_pkg::SLOT_LONG;
	assign off_neg   = offset_q[6];
	assign late_lim  = 8'sd60 + 8'(offset_q);
	assign late      = off_neg && ($signed({2'b00, ns_q}) > late_lim);

	// restoring divider step
	assign rem_shift = {div_rem_q, div_dvd_q[5]};
	assign rem_next  = (rem_shift >= {1'b0, slot_eff}) ? (rem_shift - {1'b0, slot_eff})
		: rem_shift;

	// quotient corrections after the reciprocal estimates
	assign hr_fix  = acc_q >= was_pkg::SEC_PER_HOUR;
	assign r_c     = hr_fix ? 12'(acc_q - was_pkg::SEC_PER_HOUR) : acc_q[11:0];
	assign sec_fix = acc_q >= was_pkg::SEC_PER_MIN;
	assign sec_c   = sec_fix ? 6'(acc_q - was_pkg::SEC_PER_MIN) : acc_q[5:0];

	assign year_mod = (year_q >= was_pkg::YEAR_WRAP) ? (year_q - was_pkg::YEAR_WRAP) : year_q;

	// fold the raw total into one day; raw range is about -4096..201842
	always_comb begin
		priority if (acc_q[AW-1]) begin
			wrap_k = was_pkg::SEC_PER_DAY;
		end else if (acc_q >= was_pkg::SEC_TWO_DAYS) begin
			wrap_k = -was_pkg::SEC_TWO_DAYS;
		end else if (acc_q >= was_pkg::SEC_PER_DAY) begin
			wrap_k = -was_pkg::SEC_PER_DAY;
		end else begin
			wrap_k = '0;
		end
	end

	// align: add 60 to a negative offset and borrow a minute
	always_comb begin
		al_off_c = off_neg ? (offset_q + 7'sd60) : offset_q;
		al_h_c   = {1'b0, nh_q};
		al_m_c   = nm_q;
		if (late) begin
			if (nm_q < 6'd59) begin
				al_m_c = nm_q + 6'd1;
			end else begin
				al_m_c = 6'd0;
				al_h_c = {1'b0, nh_q} + 6'd1;
			end
		end
	end

	assign slot_lim = 8'sd59 - $signed({2'b00, slot_eff}) - $signed({7'd0, al_b_q});
	// next slot boundary: minute - minute mod P + P - borrow
	assign slot_min = $signed({2'b00, al_m_q}) - $signed({2'b00, div_rem_q})
		+ $signed({2'b00, slot_eff}) - $signed({7'd0, al_b_q});

	// operands of the new alarm (hour, minute, second before carries)
	always_comb begin
		h_c = $signed(8'(alarm_h_q));
		m_c = $signed(8'(alarm_m_q));
		s_c = $signed(14'(alarm_s_q));
		unique case (cmd_q)
			was_pkg::CMD_ADVANCE: begin
				h_c = $signed(8'(alarm_h_q)) + $signed(8'(period_h_q));
				m_c = $signed(8'(alarm_m_q)) + $signed(8'(period_m_q));
				s_c = $signed(14'(alarm_s_q)) + $signed(14'(period_s_q));
			end
			was_pkg::CMD_ADJUST: begin
				s_c = $signed(14'(alarm_s_q)) + 14'(adj_q);
			end
			was_pkg::CMD_SET: begin
				h_c = $signed(8'(new_h_q));
				m_c = $signed(8'(new_m_q));
				s_c = $signed(14'(new_s_q));
			end
			was_pkg::CMD_ALIGN: begin
				s_c = 14'(al_off_q);
				priority if (slot_long && !al_b_q) begin
					h_c = $signed(8'(al_h_q)) + 8'sd1;
					m_c = 8'sd0;
				end else if (slot_long && (ns_q == 6'd0)) begin
					h_c = $signed(8'(al_h_q));
					m_c = 8'sd59;
				end else if (slot_long) begin
					h_c = $signed(8'(al_h_q)) + 8'sd1;
					m_c = 8'sd59;
				end else if (al_m_q == 6'd0) begin
					h_c = $signed(8'(al_h_q));
					m_c = $signed(8'(slot_eff)) - $signed({7'd0, al_b_q});
				end else if ($signed({2'b00, al_m_q}) < slot_lim) begin
					h_c = $signed(8'(al_h_q));
					m_c = slot_min;
				end else if (al_b_q) begin
					h_c = $signed(8'(al_h_q));
					m_c = 8'sd59;
				end else if (al_h_q == 6'd23) begin
					h_c = 8'sd0;
					m_c = $signed(8'(slot_eff));
				end else begin
					h_c = $signed(8'(al_h_q)) + 8'sd1;
					m_c = 8'sd0;
				end
			end
			default: begin
			end
		endcase
	end

	// ---- sequencer: next state and unit operands ----
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		op_a     = '0;
		op_b     = '0;
		op_c     = '0;
		unique case (state_q)
			was_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser == was_pkg::CMD_ALIGN) ? was_pkg::ST_ALIGN
						: was_pkg::ST_PREP;
				end
			end
			was_pkg::ST_ALIGN: begin
				state_d = was_pkg::ST_DIV;
			end
			was_pkg::ST_DIV: begin
				if (div_cnt_q == 3'(was_pkg::DIV_STEPS - 1)) begin
					state_d = was_pkg::ST_PREP;
				end
			end
			was_pkg::ST_PREP: begin
				state_d = was_pkg::ST_TOT_MS;
			end
			was_pkg::ST_TOT_MS: begin
				op_a    = 20'(m_q);
				op_b    = was_pkg::K_MIN;
				op_c    = 32'(s_q);
				state_d = was_pkg::ST_TOT_H;
			end
			was_pkg::ST_TOT_H: begin
				op_a    = 20'(h_q);
				op_b    = was_pkg::K_HOUR;
				op_c    = acc_q;
				state_d = was_pkg::ST_WRAP;
			end
			was_pkg::ST_WRAP: begin
				op_a    = acc_q[was_pkg::OP_A_W-1:0];
				op_b    = was_pkg::K_ONE;
				op_c    = wrap_k;
				state_d = was_pkg::ST_HOUR_Q;
			end
			was_pkg::ST_HOUR_Q: begin
				op_a    = acc_q[was_pkg::OP_A_W-1:0];
				op_b    = was_pkg::K_HOUR_RCP;
				state_d = was_pkg::ST_HOUR_R;
			end
			was_pkg::ST_HOUR_R: begin
				op_a    = $signed(20'(acc_q[was_pkg::HOUR_SHIFT+4:was_pkg::HOUR_SHIFT]));
				op_b    = was_pkg::K_NEG_HOUR;
				op_c    = $signed(32'(t_q));
				state_d = was_pkg::ST_MIN_Q;
			end
			was_pkg::ST_MIN_Q: begin
				op_a    = $signed(20'(r_c));
				op_b    = was_pkg::K_MIN_RCP;
				state_d = was_pkg::ST_MIN_R;
			end
			was_pkg::ST_MIN_R: begin
				op_a    = $signed(20'(acc_q[was_pkg::MIN_SHIFT+5:was_pkg::MIN_SHIFT]));
				op_b    = was_pkg::K_NEG_MIN;
				op_c    = $signed(32'(r_q));
				state_d = was_pkg::ST_DIFF_S;
			end
			was_pkg::ST_DIFF_S: begin
				op_a    = $signed(20'(ns_q));
				op_b    = was_pkg::K_NEG_ONE;
				op_c    = $signed(32'(t_q));
				state_d = was_pkg::ST_DIFF_M;
			end
			was_pkg::ST_DIFF_M: begin
				op_a    = $signed(20'(nm_q));
				op_b    = was_pkg::K_NEG_MIN;
				op_c    = acc_q;
				state_d = was_pkg::ST_DIFF_H;
			end
			was_pkg::ST_DIFF_H: begin
				op_a    = $signed(20'(nh_q));
				op_b    = was_pkg::K_NEG_HOUR;
				op_c    = acc_q;
				state_d = was_pkg::ST_STAMP_HM;
			end
			was_pkg::ST_STAMP_HM: begin
				op_a    = $signed(20'(nh_q));
				op_b    = was_pkg::K_HUNDRED;
				op_c    = $signed(32'(nm_q));
				state_d = was_pkg::ST_STAMP_YR;
			end
			was_pkg::ST_STAMP_YR: begin
				op_a    = $signed(20'(year_mod));
				op_b    = was_pkg::K_TEN_K;
				op_c    = acc_q;
				state_d = was_pkg::ST_STAMP_DAY;
			end
			was_pkg::ST_STAMP_DAY: begin
				op_a    = $signed(20'(day_q));
				op_b    = was_pkg::K_MILLION;
				op_c    = acc_q;
				state_d = was_pkg::ST_STAMP_MON;
			end
			was_pkg::ST_STAMP_MON: begin
				op_a    = $signed(20'(mon_q));
				op_b    = was_pkg::K_HUND_MIL;
				op_c    = acc_q;
				state_d = was_pkg::ST_STAMP_MS;
			end
			was_pkg::ST_STAMP_MS: begin
				op_a    = $signed(20'(nm_q));
				op_b    = was_pkg::K_HUNDRED;
				op_c    = $signed(32'(ns_q));
				state_d = was_pkg::ST_FINISH;
			end
			was_pkg::ST_FINISH: begin
				// keep the minute/second stamp in acc while waiting
				op_c = acc_q;
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = was_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = was_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= was_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_h_q <= '0;
			period_m_q <= '0;
			period_s_q <= '0;
			slot_q     <= was_pkg::SLOT_RESET;
			offset_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				was_pkg::CFG_PERIOD_HOURS:   period_h_q <= cfg_data[4:0];
				was_pkg::CFG_PERIOD_MINUTES: period_m_q <= cfg_data[5:0];
				was_pkg::CFG_PERIOD_SECONDS: period_s_q <= cfg_data[5:0];
				was_pkg::CFG_SLOT_MINUTES:   slot_q     <= cfg_data[5:0];
				was_pkg::CFG_SLOT_OFFSET:    offset_q   <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// stored alarm, written once the split is complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_h_q <= '0;
			alarm_m_q <= '0;
			alarm_s_q <= '0;
		end else if (state_q == was_pkg::ST_DIFF_S) begin
			alarm_h_q <= hour_q;
			alarm_m_q <= min_q + 6'(sec_fix);
			alarm_s_q <= sec_c;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {1'b0, acc_q[12:0], date_q, diff_q, alarm_s_q, alarm_m_q, alarm_h_q};
			out_user_q <= {cmd_q == was_pkg::CMD_STOP,
				(cmd_q == was_pkg::CMD_SET) || (cmd_q == was_pkg::CMD_ALIGN)};
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q   <= s_tuser;
			mon_q   <= s_tdata[3:0];
			day_q   <= s_tdata[8:4];
			year_q  <= s_tdata[15:9];
			nh_q    <= s_tdata[20:16];
			nm_q    <= s_tdata[26:21];
			ns_q    <= s_tdata[32:27];
			adj_q   <= $signed(s_tdata[45:33]);
			new_h_q <= s_tdata[50:46];
			new_m_q <= s_tdata[56:51];
			new_s_q <= s_tdata[62:57];
		end

		acc_q <= unit_res;

		unique case (state_q)
			was_pkg::ST_ALIGN: begin
				al_h_q    <= al_h_c;
				al_m_q    <= al_m_c;
				al_off_q  <= al_off_c;
				al_b_q    <= off_neg;
				div_dvd_q <= al_m_c;
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			was_pkg::ST_DIV: begin
				div_rem_q <= rem_next[5:0];
				div_dvd_q <= {div_dvd_q[4:0], 1'b0};
				div_cnt_q <= div_cnt_q + 3'd1;
			end
			was_pkg::ST_PREP: begin
				h_q <= h_c;
				m_q <= m_c;
				s_q <= s_c;
			end
			was_pkg::ST_HOUR_Q: begin
				t_q <= acc_q[16:0];
			end
			was_pkg::ST_HOUR_R: begin
				hour_q <= acc_q[was_pkg::HOUR_SHIFT+4:was_pkg::HOUR_SHIFT];
			end
			was_pkg::ST_MIN_Q: begin
				hour_q <= hour_q + 5'(hr_fix);
				r_q    <= r_c;
			end
			was_pkg::ST_MIN_R: begin
				min_q <= acc_q[was_pkg::MIN_SHIFT+5:was_pkg::MIN_SHIFT];
			end
			was_pkg::ST_STAMP_HM: begin
				diff_q <= acc_q[17:0];
			end
			was_pkg::ST_STAMP_MS: begin
				date_q <= acc_q[30:0];
			end
			default: begin
			end
		endcase
	end

endmodule
